[hdl/cdv_pkg.sv]
// Shared types and constants for the dead-band velocity step block.
package cdv_pkg;

   // Axis count and fixed field widths
   localparam int NUM_AXES  = 3;
   localparam int REG_W     = 23;
   localparam int VEL_W     = 24;
   localparam int QUO_W     = 23;
   localparam int CSR_IDX_W = 2;

   // Register stages in front of the divider
   localparam int FRONT_LAT = 3;

   // Register reset values
   localparam logic [REG_W-1:0] TOL_RESET  = 23'd655;
   localparam logic [REG_W-1:0] RATE_RESET = 23'd6554;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POS_TOL  = 2'd0,
      CSR_VEL_RATE = 2'd1
   } csr_index_type;

   // Per-axis side band that travels alongside the quotient
   typedef struct packed {
      logic neg;   // result takes the negative sign
      logic kill;  // force the velocity to zero
      logic done;  // axis inside the dead band
   } axis_flag_type;

endpackage

[hdl/cdv_front.sv]
// Front end: axis differences, magnitudes, dead-band test, L1 sum and rate products.
module cdv_front #(
   parameter int POS_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   enable,
   input  logic signed [POS_WIDTH-1:0]            meas [cdv_pkg::NUM_AXES],
   input  logic signed [POS_WIDTH-1:0]            goal [cdv_pkg::NUM_AXES],
   input  logic [cdv_pkg::REG_W-1:0]              tol,
   input  logic [cdv_pkg::REG_W-1:0]              rate,
   output logic [POS_WIDTH+1:0]                   sum_o,
   output logic [POS_WIDTH+cdv_pkg::REG_W:0]      prod_o [cdv_pkg::NUM_AXES],
   output cdv_pkg::axis_flag_type                 flag_o [cdv_pkg::NUM_AXES]
);
   import cdv_pkg::*;

   localparam int MAG_W  = POS_WIDTH + 1;
   localparam int SUM_W  = POS_WIDTH + 2;
   localparam int PROD_W = MAG_W + REG_W;
   localparam int CMP_W  = (MAG_W > REG_W) ? MAG_W : REG_W;

   logic signed [MAG_W-1:0] diff_in  [NUM_AXES];
   logic signed [MAG_W-1:0] diff_ff  [NUM_AXES];
   logic [MAG_W-1:0]        mag_in   [NUM_AXES];
   logic [MAG_W-1:0]        mag_ff   [NUM_AXES];
   logic                    neg_in   [NUM_AXES];
   logic                    neg_ff   [NUM_AXES];
   logic                    band_in  [NUM_AXES];
   logic                    band_ff  [NUM_AXES];
   logic [SUM_W-1:0]        sum_in;
   logic [SUM_W-1:0]        sum_ff;
   logic [PROD_W-1:0]       prod_in  [NUM_AXES];
   logic [PROD_W-1:0]       prod_ff  [NUM_AXES];
   axis_flag_type           flag_in  [NUM_AXES];
   axis_flag_type           flag_ff  [NUM_AXES];
   logic                    all_zero;

   // Stage 1: measured minus goal, one bit wider
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         diff_in[a] = {meas[a][POS_WIDTH-1], meas[a]} - {goal[a][POS_WIDTH-1], goal[a]};
      end
   end

   // Stage 2: magnitude, sign and dead-band test
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         mag_in[a]  = diff_ff[a][MAG_W-1] ? MAG_W'(-diff_ff[a]) : MAG_W'(diff_ff[a]);
         neg_in[a]  = !diff_ff[a][MAG_W-1] && (diff_ff[a] != '0);
         band_in[a] = CMP_W'(mag_in[a]) < CMP_W'(tol);
      end
   end

   // Stage 3: L1 sum and rate products
   always_comb begin
      all_zero = 1'b1;
      sum_in   = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         sum_in   = sum_in + SUM_W'(mag_ff[a]);
         all_zero = all_zero && (mag_ff[a] == '0);
      end
      for (int a = 0; a < NUM_AXES; a++) begin
         prod_in[a]      = PROD_W'(mag_ff[a]) * PROD_W'(rate);
         flag_in[a].neg  = neg_ff[a];
         flag_in[a].kill = band_ff[a] || all_zero;
         flag_in[a].done = band_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            diff_ff[a] <= diff_in[a];
            mag_ff[a]  <= mag_in[a];
            neg_ff[a]  <= neg_in[a];
            band_ff[a] <= band_in[a];
            prod_ff[a] <= prod_in[a];
            flag_ff[a] <= flag_in[a];
         end
         sum_ff <= sum_in;
      end
   end

   assign sum_o  = sum_ff;
   assign prod_o = prod_ff;
   assign flag_o = flag_ff;

endmodule

[hdl/cdv_divider.sv]
// Pipelined restoring divider: one quotient bit per register stage.
module cdv_divider #(
   parameter int NUM_W = 47,
   parameter int DEN_W = 26
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [NUM_W-1:0]           num,
   input  logic [DEN_W-1:0]           den,
   output logic [cdv_pkg::QUO_W-1:0]  quo
);
   import cdv_pkg::*;

   // Numerator is known to be below den * 2^QUO_W, so the top bits start below den
   logic [DEN_W-1:0] src_rem [QUO_W];
   logic [DEN_W-1:0] src_den [QUO_W];
   logic [QUO_W-1:0] src_low [QUO_W];
   logic [QUO_W-1:0] src_quo [QUO_W];
   logic [DEN_W:0]   trial   [QUO_W];
   logic             ge      [QUO_W];
   logic [DEN_W-1:0] nrem    [QUO_W-1];
   logic [QUO_W-1:0] nquo    [QUO_W];

   logic [DEN_W-1:0] rem_ff  [QUO_W-1];
   logic [DEN_W-1:0] den_ff  [QUO_W-1];
   logic [QUO_W-1:0] low_ff  [QUO_W-1];
   logic [QUO_W-1:0] quo_ff  [QUO_W];

   // Stage sources: the input for the first, the previous register after that
   always_comb begin
      src_rem[0] = DEN_W'(num[NUM_W-1:QUO_W]);
      src_den[0] = den;
      src_low[0] = num[QUO_W-1:0];
      src_quo[0] = '0;
      for (int k = 1; k < QUO_W; k++) begin
         src_rem[k] = rem_ff[k-1];
         src_den[k] = den_ff[k-1];
         src_low[k] = low_ff[k-1];
         src_quo[k] = quo_ff[k-1];
      end
   end

   // Trial subtract per stage
   always_comb begin
      for (int k = 0; k < QUO_W; k++) begin
         trial[k] = {src_rem[k], src_low[k][QUO_W-1-k]};
         ge[k]    = trial[k] >= {1'b0, src_den[k]};
         nquo[k]  = {src_quo[k][QUO_W-2:0], ge[k]};
      end
      for (int k = 0; k < QUO_W - 1; k++) begin
         nrem[k] = ge[k] ? DEN_W'(trial[k] - {1'b0, src_den[k]}) : trial[k][DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < QUO_W - 1; k++) begin
            rem_ff[k] <= nrem[k];
            den_ff[k] <= src_den[k];
            low_ff[k] <= src_low[k];
         end
         for (int k = 0; k < QUO_W; k++) begin
            quo_ff[k] <= nquo[k];
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

[hdl/cartesian_deadband_velocity_step_top.sv]
// Top level of the dead-band velocity step: registers, pipeline control and output stage.
//
// Takes one measured/goal position pair per beat and returns one velocity beat per input,
// in order. An item may enter every cycle while req_stall is low. Three front-end stages,
// 23 divider stages at one quotient bit each and one output register; the whole pipeline
// holds while a result waits under rsp_stall, so req_stall follows that alone. Per axis
// the velocity is rate * |diff| / L1 sum, truncated toward zero, signed against the
// difference; an axis inside the dead band reads zero and sets its done bit. The
// configuration port is always ready and must only be written while the pipeline is empty.
module cartesian_deadband_velocity_step_top #(
   parameter int POS_WIDTH = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [POS_WIDTH-1:0]        req_meas_x,
   input  logic signed [POS_WIDTH-1:0]        req_meas_y,
   input  logic signed [POS_WIDTH-1:0]        req_meas_z,
   input  logic signed [POS_WIDTH-1:0]        req_goal_x,
   input  logic signed [POS_WIDTH-1:0]        req_goal_y,
   input  logic signed [POS_WIDTH-1:0]        req_goal_z,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [cdv_pkg::VEL_W-1:0]   rsp_vel_x,
   output logic signed [cdv_pkg::VEL_W-1:0]   rsp_vel_y,
   output logic signed [cdv_pkg::VEL_W-1:0]   rsp_vel_z,
   output logic [cdv_pkg::NUM_AXES-1:0]       rsp_axis_done,
   output logic                               rsp_all_done,
   // configuration port
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cdv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cdv_pkg::REG_W-1:0]          csr_wdata
);
   import cdv_pkg::*;

   localparam int MAG_W    = POS_WIDTH + 1;
   localparam int SUM_W    = POS_WIDTH + 2;
   localparam int PROD_W   = MAG_W + REG_W;
   localparam int PIPE_LAT = FRONT_LAT + QUO_W;

   logic                    advance;
   logic [REG_W-1:0]        tol_ff;
   logic [REG_W-1:0]        rate_ff;
   logic [PIPE_LAT-1:0]     vld_ff;
   logic                    rsp_valid_ff;

   logic signed [POS_WIDTH-1:0] meas [NUM_AXES];
   logic signed [POS_WIDTH-1:0] goal [NUM_AXES];
   logic [SUM_W-1:0]        sum;
   logic [PROD_W-1:0]       prod     [NUM_AXES];
   axis_flag_type           flag     [NUM_AXES];
   logic [QUO_W-1:0]        quo      [NUM_AXES];
   axis_flag_type           flag_dly_ff [QUO_W][NUM_AXES];

   logic [VEL_W-1:0]        vel_in   [NUM_AXES];
   logic [VEL_W-1:0]        vel_ff   [NUM_AXES];
   logic [NUM_AXES-1:0]     done_in;
   logic [NUM_AXES-1:0]     done_ff;
   logic                    all_ff;

   // Whole pipeline moves unless a finished beat is held at the output
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff  <= TOL_RESET;
         rate_ff <= RATE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_POS_TOL:  tol_ff  <= csr_wdata;
            CSR_VEL_RATE: rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[PIPE_LAT-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_LAT-1];
      end
   end

   assign meas[0] = req_meas_x;
   assign meas[1] = req_meas_y;
   assign meas[2] = req_meas_z;
   assign goal[0] = req_goal_x;
   assign goal[1] = req_goal_y;
   assign goal[2] = req_goal_z;

   cdv_front #(
      .POS_WIDTH (POS_WIDTH)
   ) u_front (
      .clock  (clock),
      .enable (advance),
      .meas   (meas),
      .goal   (goal),
      .tol    (tol_ff),
      .rate   (rate_ff),
      .sum_o  (sum),
      .prod_o (prod),
      .flag_o (flag)
   );

   // One divider lane per axis
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      cdv_divider #(
         .NUM_W (PROD_W),
         .DEN_W (SUM_W)
      ) u_div (
         .clock  (clock),
         .enable (advance),
         .num    (prod[a]),
         .den    (sum),
         .quo    (quo[a])
      );
   end

   // Side band delay matching the divider
   always_ff @(posedge clock) begin
      if (advance) begin
         flag_dly_ff[0] <= flag;
         for (int k = 1; k < QUO_W; k++) begin
            flag_dly_ff[k] <= flag_dly_ff[k-1];
         end
      end
   end

   // Output stage: apply sign, dead band and zero-sum kill
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         if (flag_dly_ff[QUO_W-1][a].kill) begin
            vel_in[a] = '0;
         end else if (flag_dly_ff[QUO_W-1][a].neg) begin
            vel_in[a] = VEL_W'(-{1'b0, quo[a]});
         end else begin
            vel_in[a] = VEL_W'({1'b0, quo[a]});
         end
         done_in[a] = flag_dly_ff[QUO_W-1][a].done;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vel_ff  <= vel_in;
         done_ff <= done_in;
         all_ff  <= &done_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_vel_x     = vel_ff[0];
   assign rsp_vel_y     = vel_ff[1];
   assign rsp_vel_z     = vel_ff[2];
   assign rsp_axis_done = done_ff;
   assign rsp_all_done  = all_ff;

endmodule
